// ===== rtl/ahlfe_pkg.sv =====
// shared types, constants and character helpers for the ascii hex lrc frame encoder
// no dependencies
`default_nettype none

package ahlfe_pkg;

    localparam int SAMPLES_PER_FRAME = 128;
    // frame length in use is kept between 2 and 251
    localparam int FRAME_LEN = (SAMPLES_PER_FRAME < 2) ? 2 :
                               ((SAMPLES_PER_FRAME > 251) ? 251 : SAMPLES_PER_FRAME);
    localparam logic [7:0] LAST_POSITION = 8'(FRAME_LEN - 1);

    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_L    = 8'h4C;
    localparam logic [7:0] CHAR_D    = 8'h44;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_0    = 8'h30;

    typedef logic [3:0] step_t;

    // character slots of one word; slots between D and the sample are reserved zero digits
    localparam step_t STEP_STAR      = 4'd0;
    localparam step_t STEP_L         = 4'd1;
    localparam step_t STEP_D         = 4'd2;
    localparam step_t STEP_SAMPLE_HI = 4'd11;
    localparam step_t STEP_SAMPLE_LO = 4'd12;
    localparam step_t STEP_LRC_HI    = 4'd13;
    localparam step_t STEP_LRC_LO    = 4'd14;
    localparam step_t STEP_HASH      = 4'd15;

    typedef struct packed {
        logic [7:0] sample;
        logic       first;
        logic       last;
        logic [7:0] lrc;
    } job_t;

    typedef struct packed {
        logic                 empty;
        logic                 full;
        logic [JOB_CNT_W-1:0] count;
    } job_status_t;

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        logic [7:0] c;
        if (v >= 4'd10)
            c = {4'h0, v} - 8'd10 + CHAR_A;
        else
            c = {4'h0, v} + CHAR_0;
        return c;
    endfunction

    function automatic logic [7:0] char_at(input step_t step, input job_t job);
        logic [7:0] c;
        case (step)
            STEP_STAR:      c = CHAR_STAR;
            STEP_L:         c = CHAR_L;
            STEP_D:         c = CHAR_D;
            STEP_SAMPLE_HI: c = nibble_char(job.sample[7:4]);
            STEP_SAMPLE_LO: c = nibble_char(job.sample[3:0]);
            STEP_LRC_HI:    c = nibble_char(job.lrc[7:4]);
            STEP_LRC_LO:    c = nibble_char(job.lrc[3:0]);
            STEP_HASH:      c = CHAR_HASH;
            default:        c = CHAR_0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ahlfe_front.sv =====
// front end: tracks frame position and running sum, tags each sample as a job
// depends on ahlfe_pkg
`default_nettype none

module ahlfe_front
    import ahlfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [7:0]  sample,
    input  var  job_status_t status,
    output logic             full,
    output logic             wr_en,
    output job_t             wr_job
);

    logic [7:0] position_reg;
    logic [7:0] position_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] sum_new;

    assign full    = status.full;
    assign wr_en   = push && !status.full;
    assign sum_new = sum_reg + sample;

    always_comb
    begin
        wr_job.sample = sample;
        wr_job.first  = (position_reg == 8'd0);
        wr_job.last   = (position_reg == LAST_POSITION);
        wr_job.lrc    = 8'd0 - sum_new;
    end

    always_comb
    begin
        position_next = position_reg;
        sum_next      = sum_reg;
        if (wr_en)
        begin
            if (wr_job.last)
            begin
                position_next = 8'd0;
                sum_next      = 8'd0;
            end
            else
            begin
                position_next = position_reg + 8'd1;
                sum_next      = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= 8'd0;
            sum_reg      <= 8'd0;
        end
        else
        begin
            position_reg <= position_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ahlfe_job_fifo.sv =====
// short job queue between the front end and the character emitter
// depends on ahlfe_pkg
`default_nettype none

module ahlfe_job_fifo
    import ahlfe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  var  job_t  wr_job,
    input  wire logic  rd_en,
    output job_t       rd_job,
    output job_status_t status
);

    job_t                 mem_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg;
    logic [JOB_PTR_W-1:0] wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg;
    logic [JOB_PTR_W-1:0] rd_ptr_next;
    logic [JOB_CNT_W-1:0] count_reg;
    logic [JOB_CNT_W-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign status.empty = (count_reg == JOB_CNT_W'(0));
    assign status.full  = (count_reg == JOB_CNT_W'(JOB_DEPTH));
    assign status.count = count_reg;
    assign rd_job       = mem_reg[rd_ptr_reg];

    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == JOB_PTR_W'(JOB_DEPTH - 1)) ?
                          JOB_PTR_W'(0) : wr_ptr_reg + JOB_PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == JOB_PTR_W'(JOB_DEPTH - 1)) ?
                          JOB_PTR_W'(0) : rd_ptr_reg + JOB_PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + JOB_CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - JOB_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ahlfe_emitter.sv =====
// back end: steps through the characters of the head job into an output register
// depends on ahlfe_pkg
`default_nettype none

module ahlfe_emitter
    import ahlfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  var  job_t        job,
    input  var  job_status_t status,
    output logic             rd_en,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       char_out,
    output logic             last_of_run,
    output logic             frame_end
);

    logic       busy_reg;
    logic       busy_next;
    step_t      step_reg;
    step_t      step_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       fend_reg;
    step_t      cur_step;
    step_t      end_step;
    logic       advance;
    logic       at_end;

    // a fresh job starts at the header or straight at its sample digits
    assign cur_step = busy_reg ? step_reg : (job.first ? STEP_STAR : STEP_SAMPLE_HI);
    assign end_step = job.last ? STEP_HASH : STEP_SAMPLE_LO;
    assign at_end   = (cur_step == end_step);
    assign advance  = !status.empty && (!out_valid_reg || pop);
    assign rd_en    = advance && at_end;

    assign empty       = !out_valid_reg;
    assign char_out    = char_reg;
    assign last_of_run = last_reg;
    assign frame_end   = fend_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (at_end)
                busy_next = 1'b0;
            else
            begin
                busy_next = 1'b1;
                step_next = cur_step + step_t'(1);
            end
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            char_reg <= char_at(cur_step, job);
            last_reg <= at_end;
            fend_reg <= (cur_step == STEP_HASH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_STAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ascii_hex_lrc_frame_encoder_unit.sv =====
// Encodes line sensor samples as framed ASCII hex text with an LRC checksum.
// Input side is a queue: a sample word is taken on push while full is low.
// Output side is a queue: the oldest character is on char_out while empty is
// low and leaves on pop. last_of_run marks the final character of one sample,
// frame_end marks the closing '#'.
// The first sample of a frame gives 13 characters (header, eight reserved
// zero digits, two sample digits), the last gives 5 (two sample digits, two
// checksum digits, '#'), all others 2.
// The front end tags a sample in its accept cycle and writes it to a two-entry
// job queue; the emitter reads the queue head and, while a job is queued and
// the receiver keeps popping, puts out one character per cycle into a single
// output register. With the emitter idle, the first character of a sample
// passes through the job queue and then the output register to char_out;
// throughput is one character per cycle while jobs wait and the receiver pops.
// If the receiver stops popping, the output register holds, the emitter waits,
// the job queue fills and full rises; nothing is lost.
// Reset empties both queues and puts the frame at its start with a zero sum.
// depends on ahlfe_pkg, ahlfe_front, ahlfe_job_fifo, ahlfe_emitter
`default_nettype none

module ascii_hex_lrc_frame_encoder_unit
    import ahlfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] sample,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      char_out,
    output logic            last_of_run,
    output logic            frame_end
);

    job_status_t job_status;
    job_t        wr_job;
    job_t        rd_job;
    logic        wr_en;
    logic        rd_en;

    ahlfe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .sample (sample),
        .status (job_status),
        .full   (full),
        .wr_en  (wr_en),
        .wr_job (wr_job)
    );

    ahlfe_job_fifo u_job_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_job (wr_job),
        .rd_en  (rd_en),
        .rd_job (rd_job),
        .status (job_status)
    );

    ahlfe_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (rd_job),
        .status      (job_status),
        .rd_en       (rd_en),
        .pop         (pop),
        .empty       (empty),
        .char_out    (char_out),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

`ifndef NO_ASSERTIONS
    a_frame_end_char: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> (last_of_run && char_out == CHAR_HASH))
        else $error("frame end word is not a closing hash");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (job_status.count == JOB_CNT_W'(JOB_DEPTH)))
        else $error("full raised with job queue not at depth");

    a_pop_job_with_word: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (!empty && last_of_run))
        else $error("job retired without its final word shown");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for ascii_hex_lrc_frame_encoder_unit: a typed-in directed table,
// then random samples, checked against the typed-in text or an in-bench frame text predictor
// depends on ahlfe_pkg and the rtl of the encoder
`timescale 1ns / 1ps

module tb;
    import ahlfe_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       fend;
    } text_word_t;

    typedef struct {
        logic [7:0] sample;
        string      text;
    } stim_row_t;

    logic       clk    = 1'b0;
    logic       rst_n  = 1'b0;
    logic       push   = 1'b0;
    logic [7:0] sample = 8'h00;
    logic       pop    = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] char_out;
    logic       last_of_run;
    logic       frame_end;

    text_word_t expected_text[$];
    text_word_t char_batch[$];
    logic [7:0] frame_pos  = 8'd0;
    logic [7:0] frame_sum  = 8'd0;
    int         send_idle  = 0;
    int         recv_idle  = 0;
    int         mismatches = 0;

    // empty text means the row is checked against the predictor
    stim_row_t directed_rows[20] = '{
        '{8'h00, "*LD0000000000"},
        '{8'hFF, "FF"},
        '{8'h0A, "0A"},
        '{8'hA0, "A0"},
        '{8'h01, "01"},
        '{8'h23, "23"},
        '{8'h45, "45"},
        '{8'h67, "67"},
        '{8'h89, "89"},
        '{8'hAB, "AB"},
        '{8'hCD, "CD"},
        '{8'hEF, "EF"},
        '{8'h9A, "9A"},
        '{8'hF0, "F0"},
        '{8'h80, "80"},
        '{8'h7F, "7F"},
        '{8'h3C, ""},
        '{8'h55, ""},
        '{8'hAA, ""},
        '{8'hC3, ""}
    };

    ascii_hex_lrc_frame_encoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample      (sample),
        .empty       (empty),
        .pop         (pop),
        .char_out    (char_out),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v > 4'd9)
            c = CHAR_A + {4'h0, v} - 8'd10;
        else
            c = CHAR_0 + {4'h0, v};
        return c;
    endfunction

    task automatic add_char(input logic [7:0] c, input logic fend);
        char_batch.push_back({c, 1'b0, fend});
    endtask

    task automatic add_hex(input logic [7:0] b);
        add_char(hex_char(b[7:4]), 1'b0);
        add_char(hex_char(b[3:0]), 1'b0);
    endtask

    // builds the characters of one sample and advances frame position and lrc sum
    task automatic encode_sample(input logic [7:0] s, input bit keep);
        text_word_t w;
        char_batch.delete();
        if (frame_pos == 8'd0)
        begin
            add_char(CHAR_STAR, 1'b0);
            add_char(CHAR_L, 1'b0);
            add_char(CHAR_D, 1'b0);
            repeat (4) add_hex(8'h00);
        end
        add_hex(s);
        frame_sum = frame_sum + s;
        if (int'(frame_pos) == FRAME_LEN - 1)
        begin
            add_hex(8'h00 - frame_sum);
            add_char(CHAR_HASH, 1'b1);
            frame_pos = 8'd0;
            frame_sum = 8'd0;
        end
        else
        begin
            frame_pos = frame_pos + 8'd1;
        end
        w = char_batch.pop_back();
        w.last = 1'b1;
        char_batch.push_back(w);
        if (keep)
        begin
            foreach (char_batch[i])
                expected_text.push_back(char_batch[i]);
        end
    endtask

    task automatic send_word(input logic [7:0] s, input string text);
        text_word_t w;
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push   <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        encode_sample(s, text.len() == 0);
        for (int i = 0; i < text.len(); i++)
        begin
            w.ch   = text[i];
            w.last = (i == text.len() - 1);
            w.fend = (text[i] == CHAR_HASH);
            expected_text.push_back(w);
        end
    endtask

    task automatic send_random(input int count);
        logic [7:0] s;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 7))
                0:       s = 8'h00;
                1:       s = 8'hFF;
                default: s = 8'($urandom_range(0, 255));
            endcase
            send_word(s, "");
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : char_check
        text_word_t got;
        text_word_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got = {char_out, last_of_run, frame_end};
                if (expected_text.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: char %h last %b end %b",
                                 got.ch, got.last, got.fend);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: char %h/%h last %b/%b end %b/%b (exp/act)",
                                     want.ch, got.ch, want.last, got.last,
                                     want.fend, got.fend);
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 18;
        recv_idle = 58;
        foreach (directed_rows[i])
            send_word(directed_rows[i].sample, directed_rows[i].text);
        send_random(80);
        // hold the sender off until the output side runs dry
        wait_drained();

        send_idle = 58;
        recv_idle = 18;
        send_random(85);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        send_random(85);
        wait_drained();

        repeat (16) @(posedge clk);
        if (mismatches == 0 && expected_text.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ahlfe_pkg.sv
rtl/ahlfe_front.sv
rtl/ahlfe_job_fifo.sv
rtl/ahlfe_emitter.sv
rtl/ascii_hex_lrc_frame_encoder_unit.sv
tb/tb.sv
